@@ sv/aafc_pkg.sv @@
// ----------------------------------------------------------------------------
// aafc_pkg
// shared constants and types for the box frustum cull pipeline
// ----------------------------------------------------------------------------
package aafc_pkg;

    localparam int COORD_WIDTH_DEF = 21;   // default coordinate width, Q10.10
    localparam int COORD_FRAC      = 10;   // fraction bits of a coordinate
    localparam int FIELD_W         = 63;   // packed xyz input word
    localparam int NUM_AXES        = 3;

    localparam int NUM_PLANES      = 6;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int NORM_W          = 14;   // Q1.12 normal component
    localparam int OFFS_W          = 22;   // Q11.10 plane offset
    localparam int OFFS_POS        = NUM_AXES * NORM_W;
    localparam int OFFS_SHIFT      = 22;   // aligns offset to 32 fraction bits

    localparam int PIPE_DEPTH      = 5;
    localparam int FLIGHT_W        = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        PLANE_RIGHT  = 3'd0,
        PLANE_LEFT   = 3'd1,
        PLANE_TOP    = 3'd2,
        PLANE_BOTTOM = 3'd3,
        PLANE_NEAR   = 3'd4,
        PLANE_FAR    = 3'd5
    } t_plane_idx;

endpackage

@@ sv/aafc_if.sv @@
// ----------------------------------------------------------------------------
// aafc_in_if / aafc_out_if
// valid/ready channels carrying one object and its cull result
// ----------------------------------------------------------------------------
interface aafc_in_if;
    logic                         valid;
    logic                         ready;
    logic [aafc_pkg::FIELD_W-1:0] matrix_col_x;
    logic [aafc_pkg::FIELD_W-1:0] matrix_col_y;
    logic [aafc_pkg::FIELD_W-1:0] matrix_col_z;
    logic [aafc_pkg::FIELD_W-1:0] matrix_translation;
    logic [aafc_pkg::FIELD_W-1:0] box_center;
    logic [aafc_pkg::FIELD_W-1:0] box_extents;

    modport source (
        output valid, matrix_col_x, matrix_col_y, matrix_col_z,
               matrix_translation, box_center, box_extents,
        input  ready
    );
    modport sink (
        input  valid, matrix_col_x, matrix_col_y, matrix_col_z,
               matrix_translation, box_center, box_extents,
        output ready
    );
endinterface

interface aafc_out_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

@@ sv/aafc_xform.sv @@
// ----------------------------------------------------------------------------
// aafc_xform
// two-stage world transform: center and abs-extent products, then row sums
// ----------------------------------------------------------------------------
module aafc_xform #(
    parameter int COORD_WIDTH = aafc_pkg::COORD_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [aafc_pkg::FIELD_W-1:0] i_mat_x,
    input  logic [aafc_pkg::FIELD_W-1:0] i_mat_y,
    input  logic [aafc_pkg::FIELD_W-1:0] i_mat_z,
    input  logic [aafc_pkg::FIELD_W-1:0] i_trans,
    input  logic [aafc_pkg::FIELD_W-1:0] i_center,
    input  logic [aafc_pkg::FIELD_W-1:0] i_extents,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [2*COORD_WIDTH:0]   o_g   [aafc_pkg::NUM_AXES],
    output logic        [2*COORD_WIDTH-1:0] o_len [aafc_pkg::NUM_AXES]
);

    localparam int CW  = COORD_WIDTH;
    localparam int NA  = aafc_pkg::NUM_AXES;
    localparam int P_W = 2 * CW;
    localparam int G_W = 2 * CW + 1;

    logic [aafc_pkg::FIELD_W-1:0] col [NA];
    logic signed [CW-1:0] m [NA][NA];     // m[column][axis]
    logic signed [CW-1:0] c [NA];
    logic signed [CW-1:0] e [NA];
    logic        [CW-1:0] am [NA][NA];
    logic        [CW-1:0] ae [NA];

    logic signed [P_W-1:0] n1_cprod [NA][NA];
    logic        [P_W-1:0] n1_eprod [NA][NA];
    logic signed [P_W-1:0] r1_cprod [NA][NA];
    logic        [P_W-1:0] r1_eprod [NA][NA];
    logic signed [CW-1:0]  r1_t [NA];
    logic                  r1_v;

    logic signed [G_W-1:0] n2_g [NA];
    logic        [P_W-1:0] n2_len [NA];
    logic signed [G_W-1:0] r2_g [NA];
    logic        [P_W-1:0] r2_len [NA];
    logic                  r2_v;

    logic en1, en2;

    assign en2     = !r2_v || i_ready;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;
    assign o_valid = r2_v;

    assign col[0] = i_mat_x;
    assign col[1] = i_mat_y;
    assign col[2] = i_mat_z;

    // stage 1: products, extents through magnitudes so no abs after the multiply
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            c[i]  = i_center[i*CW +: CW];
            e[i]  = i_extents[i*CW +: CW];
            ae[i] = e[i][CW-1] ? CW'(-e[i]) : CW'(e[i]);
            for (int j = 0; j < NA; j++) begin
                m[j][i]  = col[j][i*CW +: CW];
                am[j][i] = m[j][i][CW-1] ? CW'(-m[j][i]) : CW'(m[j][i]);
            end
        end
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NA; j++) begin
                n1_cprod[i][j] = P_W'(m[j][i]) * P_W'(c[j]);
                n1_eprod[i][j] = P_W'(am[j][i]) * P_W'(ae[j]);
            end
        end
    end

    // stage 2: row sums, translation aligned to 20 fraction bits
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n2_g[i] = G_W'(r1_cprod[i][0]) + G_W'(r1_cprod[i][1])
                    + G_W'(r1_cprod[i][2])
                    + (G_W'(r1_t[i]) <<< aafc_pkg::COORD_FRAC);
            n2_len[i] = r1_eprod[i][0] + r1_eprod[i][1] + r1_eprod[i][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_valid;
            if (en2) r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r1_cprod <= n1_cprod;
            r1_eprod <= n1_eprod;
            for (int i = 0; i < NA; i++) begin
                r1_t[i] <= i_trans[i*CW +: CW];
            end
        end
        if (en2 && r1_v) begin
            r2_g   <= n2_g;
            r2_len <= n2_len;
        end
    end

    assign o_g   = r2_g;
    assign o_len = r2_len;

endmodule

@@ sv/aafc_cull.sv @@
// ----------------------------------------------------------------------------
// aafc_cull
// three-stage plane test: plane products, distance and radius sums, verdict
// ----------------------------------------------------------------------------
module aafc_cull #(
    parameter int COORD_WIDTH = aafc_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [aafc_pkg::CFG_W-1:0]  i_plane [aafc_pkg::NUM_PLANES],
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [2*COORD_WIDTH:0]   i_g   [aafc_pkg::NUM_AXES],
    input  logic        [2*COORD_WIDTH-1:0] i_len [aafc_pkg::NUM_AXES],
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_visible
);

    localparam int NA    = aafc_pkg::NUM_AXES;
    localparam int NP    = aafc_pkg::NUM_PLANES;
    localparam int NW    = aafc_pkg::NORM_W;
    localparam int G_W   = 2 * COORD_WIDTH + 1;
    localparam int L_W   = 2 * COORD_WIDTH;
    localparam int DP_W  = G_W + NW;
    localparam int RP_W  = L_W + NW;
    localparam int OD_W  = aafc_pkg::OFFS_W + aafc_pkg::OFFS_SHIFT;
    localparam int D_W   = ((DP_W + 2 > OD_W) ? DP_W + 2 : OD_W) + 1;
    localparam int R_W   = RP_W + 2;
    localparam int S_W   = ((D_W > R_W + 1) ? D_W : R_W + 1) + 1;

    logic signed [NW-1:0] nrm [NP][NA];
    logic        [NW-1:0] anrm [NP][NA];
    logic signed [aafc_pkg::OFFS_W-1:0] offs [NP];

    logic signed [DP_W-1:0] n3_dprod [NP][NA];
    logic        [RP_W-1:0] n3_rprod [NP][NA];
    logic signed [DP_W-1:0] r3_dprod [NP][NA];
    logic        [RP_W-1:0] r3_rprod [NP][NA];
    logic                   r3_v;

    logic signed [D_W-1:0]  n4_dist [NP];
    logic        [R_W-1:0]  n4_rad  [NP];
    logic signed [D_W-1:0]  r4_dist [NP];
    logic        [R_W-1:0]  r4_rad  [NP];
    logic                   r4_v;

    logic [S_W-1:0] sum [NP];
    logic [NP-1:0]  pass;
    logic           r5_vis;
    logic           r5_v;

    logic en3, en4, en5;

    assign en5     = !r5_v || i_ready;
    assign en4     = !r4_v || en5;
    assign en3     = !r3_v || en4;
    assign o_ready = en3;
    assign o_valid = r5_v;

    // the user must keep plane words static while items are in flight, the block does not enforce it
    always_comb begin
        for (int p = 0; p < NP; p++) begin
            offs[p] = i_plane[p][aafc_pkg::OFFS_POS +: aafc_pkg::OFFS_W];
            for (int k = 0; k < NA; k++) begin
                nrm[p][k]  = i_plane[p][k*NW +: NW];
                anrm[p][k] = nrm[p][k][NW-1] ? NW'(-nrm[p][k]) : NW'(nrm[p][k]);
                n3_dprod[p][k] = DP_W'(nrm[p][k]) * DP_W'(i_g[k]);
                n3_rprod[p][k] = RP_W'(anrm[p][k]) * RP_W'(i_len[k]);
            end
        end
    end

    always_comb begin
        for (int p = 0; p < NP; p++) begin
            n4_dist[p] = D_W'(r3_dprod[p][0]) + D_W'(r3_dprod[p][1])
                       + D_W'(r3_dprod[p][2])
                       - (D_W'(offs[p]) <<< aafc_pkg::OFFS_SHIFT);
            n4_rad[p]  = R_W'(r3_rprod[p][0]) + R_W'(r3_rprod[p][1])
                       + R_W'(r3_rprod[p][2]);
        end
    end

    // plane passes when dist + rad is not negative
    always_comb begin
        for (int p = 0; p < NP; p++) begin
            sum[p]  = S_W'(r4_dist[p]) + S_W'(r4_rad[p]);
            pass[p] = !sum[p][S_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (en3) r3_v <= i_valid;
            if (en4) r4_v <= r3_v;
            if (en5) r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && i_valid) begin
            r3_dprod <= n3_dprod;
            r3_rprod <= n3_rprod;
        end
        if (en4 && r3_v) begin
            r4_dist <= n4_dist;
            r4_rad  <= n4_rad;
        end
        if (en5 && r4_v) begin
            r5_vis <= &pass;
        end
    end

    assign o_visible = r5_vis;

endmodule

@@ sv/aabb_frustum_cull.sv @@
// an input transfer passes r1, r2 in aafc_xform and r3, r4, r5 in aafc_cull
// throughput: one object per cycle; each stage holds one item and stalls only
//   when it is full and the stage after it is stalled, so bubbles close up
// stage depth is set by the plane multiplies: 36 products, 14 by 42 or 43 bits
// reset: clears all stage valid bits and the six plane registers to zero
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// six-plane frustum cull of a transformed axis-aligned box, pipelined
// ----------------------------------------------------------------------------
module aabb_frustum_cull #(
    parameter int COORD_WIDTH = aafc_pkg::COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [aafc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [aafc_pkg::CFG_W-1:0]     i_cfg_wdata,
    aafc_in_if.sink                        i_item,
    aafc_out_if.source                     o_result
);

    localparam int NP = aafc_pkg::NUM_PLANES;
    localparam int NA = aafc_pkg::NUM_AXES;

    logic [aafc_pkg::CFG_W-1:0] r_plane [NP];

    logic                         xf_valid;
    logic                         xf_ready;
    logic signed [2*COORD_WIDTH:0]   xf_g   [NA];
    logic        [2*COORD_WIDTH-1:0] xf_len [NA];

    logic [aafc_pkg::FLIGHT_W-1:0] r_flight;
    logic [aafc_pkg::FLIGHT_W-1:0] n_flight;
    logic                          in_xfer;
    logic                          out_xfer;

    // writes past the last plane fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NP; p++) begin
                r_plane[p] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int p = 0; p < NP; p++) begin
                if (i_cfg_idx == aafc_pkg::CFG_IDX_W'(p)) begin
                    r_plane[p] <= i_cfg_wdata;
                end
            end
        end
    end

    aafc_xform #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_xform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_item.valid),
        .o_ready   (i_item.ready),
        .i_mat_x   (i_item.matrix_col_x),
        .i_mat_y   (i_item.matrix_col_y),
        .i_mat_z   (i_item.matrix_col_z),
        .i_trans   (i_item.matrix_translation),
        .i_center  (i_item.box_center),
        .i_extents (i_item.box_extents),
        .o_valid   (xf_valid),
        .i_ready   (xf_ready),
        .o_g       (xf_g),
        .o_len     (xf_len)
    );

    aafc_cull #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cull (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_plane   (r_plane),
        .i_valid   (xf_valid),
        .o_ready   (xf_ready),
        .i_g       (xf_g),
        .i_len     (xf_len),
        .o_valid   (o_result.valid),
        .i_ready   (o_result.ready),
        .o_visible (o_result.visible)
    );

    // items inside the pipeline, for the checks below
    assign in_xfer  = i_item.valid && i_item.ready;
    assign out_xfer = o_result.valid && o_result.ready;

    always_comb begin
        n_flight = r_flight;
        if (in_xfer && !out_xfer) begin
            n_flight = r_flight + 1'b1;
        end else if (!in_xfer && out_xfer) begin
            n_flight = r_flight - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flight <= '0;
        end else begin
            r_flight <= n_flight;
        end
    end

    a_flight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flight <= aafc_pkg::FLIGHT_W'(aafc_pkg::PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

    a_empty_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flight == '0) |-> !o_result.valid)
        else $error("result presented with no item in flight");

    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.ready |-> i_item.ready)
        else $error("input stalled while output side is ready");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flight == aafc_pkg::FLIGHT_W'(aafc_pkg::PIPE_DEPTH)) && !o_result.ready
        |-> !i_item.ready)
        else $error("input accepted into a full stalled pipeline");

endmodule

@@ tb/tb_aabb_frustum_cull.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aabb_frustum_cull
// drives objects through the six-plane box cull and checks each visible flag
// against a row flag or a cycle-free integer model of transform and plane
// tests; planes reload per phase; phases 0-3 stall both channels at random
// ----------------------------------------------------------------------------
module tb_aabb_frustum_cull;

    localparam int FIELD_W     = aafc_pkg::FIELD_W;
    localparam int CFG_W       = aafc_pkg::CFG_W;
    localparam int CFG_IDX_W   = aafc_pkg::CFG_IDX_W;
    localparam int NUM_AXES    = aafc_pkg::NUM_AXES;
    localparam int NUM_PLANES  = aafc_pkg::NUM_PLANES;
    localparam int NORM_W      = aafc_pkg::NORM_W;
    localparam int OFFS_W      = aafc_pkg::OFFS_W;
    localparam int OFFS_POS    = aafc_pkg::OFFS_POS;
    localparam int OFFS_SHIFT  = aafc_pkg::OFFS_SHIFT;
    localparam int COORD_FRAC  = aafc_pkg::COORD_FRAC;
    localparam int PIPE_DEPTH  = aafc_pkg::PIPE_DEPTH;

    localparam int CW          = aafc_pkg::COORD_WIDTH_DEF;
    localparam int ONE_Q       = 1 << COORD_FRAC;      // 1.0 as a coordinate
    localparam int NORM_ONE    = 1 << 12;              // 1.0 as a normal component
    localparam int CMAX        = (1 << (CW - 1)) - 1;
    localparam int CMIN        = -(1 << (CW - 1));
    localparam int NMAX        = (1 << (NORM_W - 1)) - 1;
    localparam int NMIN        = -(1 << (NORM_W - 1));
    localparam int OMAX        = (1 << (OFFS_W - 1)) - 1;
    localparam int OMIN        = -(1 << (OFFS_W - 1));
    localparam int IDLE_LIGHT  = 13;
    localparam int IDLE_HEAVY  = 71;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 180;

    // indexes past the last plane, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [FIELD_W-1:0] col_x;
        logic [FIELD_W-1:0] col_y;
        logic [FIELD_W-1:0] col_z;
        logic [FIELD_W-1:0] trans;
        logic [FIELD_W-1:0] center;
        logic [FIELD_W-1:0] extents;
    } t_obj;

    typedef struct {
        t_obj obj;
        bit   typed;    // expected flag given in the row itself
        logic want;
    } t_cull_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    aafc_in_if  obj_ch ();
    aafc_out_if res_ch ();

    aabb_frustum_cull DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (obj_ch),
        .o_result    (res_ch)
    );

    logic [CFG_W-1:0] plane_copy [NUM_PLANES];
    logic [CFG_W-1:0] plane_stage [NUM_PLANES];
    logic             pending_visible [$];
    t_cull_row        directed_rows [$];
    int               mismatch_cnt = 0;
    int               src_idle_pct;
    int               snk_idle_pct;
    logic             vis_want;
    t_obj             stim_obj;
    int               frustum_k;
    bit               planes_aimed;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // cull model
    // ------------------------------------------------------------------
    function automatic longint coord_at(input logic [FIELD_W-1:0] w, input int k);
        logic signed [CW-1:0] v;
        v = w[k*CW +: CW];
        return v;
    endfunction

    function automatic longint norm_at(input logic [CFG_W-1:0] w, input int k);
        logic signed [NORM_W-1:0] v;
        v = w[k*NORM_W +: NORM_W];
        return v;
    endfunction

    function automatic longint offs_at(input logic [CFG_W-1:0] w);
        logic signed [OFFS_W-1:0] v;
        v = w[OFFS_POS +: OFFS_W];
        return v;
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic cull_visible(input t_obj o);
        longint cc [3];
        longint ee [3];
        longint wc [3];
        longint hl [3];
        longint m0, m1, m2, nx, ny, nz, sdist, rad;
        logic   vis;
        vis = 1'b1;
        for (int k = 0; k < NUM_AXES; k++) begin
            cc[k] = coord_at(o.center, k);
            ee[k] = coord_at(o.extents, k);
        end
        // world center and half-extents carry 20 fraction bits
        for (int i = 0; i < NUM_AXES; i++) begin
            m0 = coord_at(o.col_x, i);
            m1 = coord_at(o.col_y, i);
            m2 = coord_at(o.col_z, i);
            wc[i] = m0 * cc[0] + m1 * cc[1] + m2 * cc[2]
                  + coord_at(o.trans, i) * (longint'(1) << COORD_FRAC);
            hl[i] = mag(m0 * ee[0]) + mag(m1 * ee[1]) + mag(m2 * ee[2]);
        end
        // plane sums carry 32 fraction bits
        for (int p = 0; p < NUM_PLANES; p++) begin
            nx    = norm_at(plane_copy[p], 0);
            ny    = norm_at(plane_copy[p], 1);
            nz    = norm_at(plane_copy[p], 2);
            sdist = nx * wc[0] + ny * wc[1] + nz * wc[2]
                  - offs_at(plane_copy[p]) * (longint'(1) << OFFS_SHIFT);
            rad   = hl[0] * mag(nx) + hl[1] * mag(ny) + hl[2] * mag(nz);
            if (sdist + rad < 0) begin
                vis = 1'b0;
            end
        end
        return vis;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [FIELD_W-1:0] pack_xyz(input int x, input int y, input int z);
        logic [FIELD_W-1:0] w;
        w = '0;
        w[0 +: CW]    = x[CW-1:0];
        w[CW +: CW]   = y[CW-1:0];
        w[2*CW +: CW] = z[CW-1:0];
        return w;
    endfunction

    function automatic logic [CFG_W-1:0] pack_plane(input int nx, input int ny,
                                                   input int nz, input int off);
        logic [NORM_W-1:0] bx, by, bz;
        logic [OFFS_W-1:0] bo;
        bx = nx[NORM_W-1:0];
        by = ny[NORM_W-1:0];
        bz = nz[NORM_W-1:0];
        bo = off[OFFS_W-1:0];
        return {bo, bz, by, bx};
    endfunction

    function automatic logic [CFG_W-1:0] rand_bits64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [FIELD_W-1:0] rand_field();
        logic [CFG_W-1:0] w;
        w = rand_bits64();
        return w[FIELD_W-1:0];
    endfunction

    function automatic int srand(input int lim);
        int l;
        l = (lim > CMAX) ? CMAX : lim;
        return int'($urandom_range(2 * l)) - l;
    endfunction

    function automatic t_obj obj_of(input logic [FIELD_W-1:0] mx, input logic [FIELD_W-1:0] my,
                                    input logic [FIELD_W-1:0] mz, input logic [FIELD_W-1:0] t,
                                    input logic [FIELD_W-1:0] c, input logic [FIELD_W-1:0] e);
        t_obj o;
        o.col_x   = mx;
        o.col_y   = my;
        o.col_z   = mz;
        o.trans   = t;
        o.center  = c;
        o.extents = e;
        return o;
    endfunction

    // mostly matrices with entries in +-1.0 placed around a box of size span, some raw noise
    function automatic t_obj rand_obj(input int span);
        t_obj o;
        if ($urandom_range(99) < 25) begin
            o = obj_of(rand_field(), rand_field(), rand_field(),
                       rand_field(), rand_field(), rand_field());
        end else begin
            o.col_x   = pack_xyz(srand(ONE_Q), srand(ONE_Q), srand(ONE_Q));
            o.col_y   = pack_xyz(srand(ONE_Q), srand(ONE_Q), srand(ONE_Q));
            o.col_z   = pack_xyz(srand(ONE_Q), srand(ONE_Q), srand(ONE_Q));
            o.trans   = pack_xyz(srand(span * 3 / 2), srand(span * 3 / 2),
                                 srand(span * 3 / 2));
            o.center  = pack_xyz(srand(span / 4), srand(span / 4), srand(span / 4));
            o.extents = pack_xyz(srand(span / 4), srand(span / 4), srand(span / 4));
        end
        return o;
    endfunction

    function automatic void add_row(input t_obj o, input bit typed, input logic want);
        t_cull_row r;
        r.obj   = o;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    // cube of half-size k around the origin, normals pointing inward
    function automatic void stage_frustum(input int k);
        plane_stage[aafc_pkg::PLANE_RIGHT]  =
            pack_plane(-NORM_ONE + srand(64), srand(64), srand(64), -k);
        plane_stage[aafc_pkg::PLANE_LEFT]   =
            pack_plane(NORM_ONE + srand(64), srand(64), srand(64), -k);
        plane_stage[aafc_pkg::PLANE_TOP]    =
            pack_plane(srand(64), -NORM_ONE + srand(64), srand(64), -k);
        plane_stage[aafc_pkg::PLANE_BOTTOM] =
            pack_plane(srand(64), NORM_ONE + srand(64), srand(64), -k);
        plane_stage[aafc_pkg::PLANE_NEAR]   =
            pack_plane(srand(64), srand(64), NORM_ONE + srand(64), -k);
        plane_stage[aafc_pkg::PLANE_FAR]    =
            pack_plane(srand(64), srand(64), -NORM_ONE + srand(64), -k);
    endfunction

    function automatic void build_directed();
        logic [FIELD_W-1:0] id_x, id_y, id_z, rot_x, rot_y, zero_f;
        int e;
        e      = 3 * ONE_Q;
        zero_f = '0;
        id_x   = pack_xyz(ONE_Q, 0, 0);
        id_y   = pack_xyz(0, ONE_Q, 0);
        id_z   = pack_xyz(0, 0, ONE_Q);
        rot_x  = pack_xyz(0, ONE_Q, 0);
        rot_y  = pack_xyz(-ONE_Q, 0, 0);
        // all planes zero after reset: every object is visible
        add_row(obj_of(zero_f, zero_f, zero_f, zero_f, zero_f, zero_f), 1'b1, 1'b1);
        add_row(obj_of('1, '1, '1, '1, '1, '1), 1'b1, 1'b1);
        add_row(obj_of(pack_xyz(CMAX, CMAX, CMAX), pack_xyz(CMAX, CMAX, CMAX),
                       pack_xyz(CMAX, CMAX, CMAX), pack_xyz(CMAX, CMAX, CMAX),
                       pack_xyz(CMAX, CMAX, CMAX), pack_xyz(CMAX, CMAX, CMAX)), 1'b1, 1'b1);
        add_row(obj_of(pack_xyz(CMIN, CMIN, CMIN), pack_xyz(CMIN, CMIN, CMIN),
                       pack_xyz(CMIN, CMIN, CMIN), pack_xyz(CMIN, CMIN, CMIN),
                       pack_xyz(CMIN, CMIN, CMIN), pack_xyz(CMIN, CMIN, CMIN)), 1'b1, 1'b1);
        add_row(obj_of(pack_xyz(CMIN, CMAX, CMIN), pack_xyz(CMAX, CMIN, CMAX),
                       pack_xyz(CMIN, CMAX, CMIN), pack_xyz(CMAX, CMIN, CMAX),
                       pack_xyz(CMIN, CMAX, CMIN), pack_xyz(CMAX, CMIN, CMAX)), 1'b1, 1'b1);
        // single half-space x >= 0 from here on
        add_row(obj_of(id_x, id_y, id_z, zero_f, pack_xyz(-e, 0, 0), pack_xyz(e, e, e)),
                1'b0, 1'b0);
        add_row(obj_of(id_x, id_y, id_z, zero_f, pack_xyz(-e - 1, 0, 0), pack_xyz(e, e, e)),
                1'b0, 1'b0);
        // negative extents count by magnitude
        add_row(obj_of(id_x, id_y, id_z, zero_f, pack_xyz(-e, 0, 0), pack_xyz(-e, -e, -e)),
                1'b0, 1'b0);
        add_row(obj_of(id_x, id_y, id_z, zero_f, pack_xyz(-e - 1, 0, 0), pack_xyz(-e, -e, -e)),
                1'b0, 1'b0);
        add_row(obj_of(id_x, id_y, id_z, zero_f, zero_f, zero_f), 1'b0, 1'b0);
        add_row(obj_of(id_x, id_y, id_z, zero_f, pack_xyz(-1, 0, 0), zero_f), 1'b0, 1'b0);
        add_row(obj_of(id_x, id_y, id_z, pack_xyz(5 * ONE_Q, 0, 0),
                       pack_xyz(-5 * ONE_Q, 0, 0), zero_f), 1'b0, 1'b0);
        // quarter turn maps local y onto world -x
        add_row(obj_of(rot_x, rot_y, id_z, zero_f, pack_xyz(0, 2 * ONE_Q, 0), zero_f),
                1'b0, 1'b0);
        add_row(obj_of(rot_x, rot_y, id_z, zero_f, pack_xyz(0, 2 * ONE_Q, 0),
                       pack_xyz(0, e, 0)), 1'b0, 1'b0);
        add_row(obj_of(pack_xyz(CMIN, CMIN, CMIN), pack_xyz(CMIN, CMIN, CMIN),
                       pack_xyz(CMIN, CMIN, CMIN), pack_xyz(CMIN, CMIN, CMIN),
                       pack_xyz(CMAX, CMAX, CMAX), pack_xyz(CMIN, CMIN, CMIN)), 1'b0, 1'b0);
        add_row(obj_of(pack_xyz(CMAX, CMAX, CMAX), pack_xyz(CMAX, CMAX, CMAX),
                       pack_xyz(CMAX, CMAX, CMAX), pack_xyz(CMIN, CMIN, CMIN),
                       pack_xyz(CMAX, CMAX, CMAX), pack_xyz(CMAX, CMAX, CMAX)), 1'b0, 1'b0);
        add_row(obj_of('1, '1, '1, '1, '1, '1), 1'b0, 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // channel and register drivers
    // ------------------------------------------------------------------
    task automatic send_obj(input t_obj o, input logic want);
        while ($urandom_range(99) < src_idle_pct) begin
            obj_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        obj_ch.valid              <= 1'b1;
        obj_ch.matrix_col_x       <= o.col_x;
        obj_ch.matrix_col_y       <= o.col_y;
        obj_ch.matrix_col_z       <= o.col_z;
        obj_ch.matrix_translation <= o.trans;
        obj_ch.box_center         <= o.center;
        obj_ch.box_extents        <= o.extents;
        @(posedge i_clk);
        while (!obj_ch.ready) @(posedge i_clk);
        pending_visible.push_back(want);
    endtask

    // leaves the write enable high, the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx < NUM_PLANES) begin
            plane_copy[idx] = val;
        end
    endtask

    task automatic commit_planes();
        for (int p = 0; p < NUM_PLANES; p++) begin
            write_reg(aafc_pkg::t_plane_idx'(p), plane_stage[p]);
        end
    endtask

    task automatic wait_drained();
        while (pending_visible.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_visible.size() == 0) begin
                $error("visible: expected no transfer, actual %0b", res_ch.visible);
                mismatch_cnt++;
            end else begin
                vis_want = pending_visible.pop_front();
                if (res_ch.visible !== vis_want) begin
                    $error("visible: expected %0b, actual %0b", vis_want, res_ch.visible);
                    mismatch_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n                   = 1'b0;
        i_cfg_we                  = 1'b0;
        i_cfg_idx                 = '0;
        i_cfg_wdata               = '0;
        obj_ch.valid              = 1'b0;
        obj_ch.matrix_col_x       = '0;
        obj_ch.matrix_col_y       = '0;
        obj_ch.matrix_col_z       = '0;
        obj_ch.matrix_translation = '0;
        obj_ch.box_center         = '0;
        obj_ch.box_extents        = '0;
        src_idle_pct              = 0;
        snk_idle_pct              = 0;
        planes_aimed              = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            plane_copy[p]  = '0;
            plane_stage[p] = '0;
        end
        build_directed();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (!directed_rows[r].typed && !planes_aimed) begin
                obj_ch.valid <= 1'b0;
                wait_drained();
                for (int p = 0; p < NUM_PLANES; p++) begin
                    plane_stage[p] = '0;
                end
                plane_stage[aafc_pkg::PLANE_RIGHT] = pack_plane(NORM_ONE, 0, 0, 0);
                commit_planes();
                write_reg(CFG_IDX_SPARE_LO, '1);
                write_reg(CFG_IDX_SPARE_HI, rand_bits64());
                i_cfg_we     <= 1'b0;
                planes_aimed  = 1'b1;
            end
            send_obj(directed_rows[r].obj,
                     directed_rows[r].typed ? directed_rows[r].want
                                            : cull_visible(directed_rows[r].obj));
        end
        obj_ch.valid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph / 2)
                0: begin
                    src_idle_pct = IDLE_LIGHT;
                    snk_idle_pct = IDLE_HEAVY;
                end
                1: begin
                    src_idle_pct = IDLE_HEAVY;
                    snk_idle_pct = IDLE_LIGHT;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            frustum_k = int'($urandom_range(600, 2)) * ONE_Q;
            case (ph)
                1: begin
                    for (int p = 0; p < NUM_PLANES; p++) plane_stage[p] = '1;
                end
                2: begin
                    for (int p = 0; p < NUM_PLANES; p++) begin
                        plane_stage[p] = pack_plane(NMAX, NMAX, NMAX, OMIN);
                    end
                end
                3: begin
                    for (int p = 0; p < NUM_PLANES; p++) begin
                        plane_stage[p] = pack_plane(NMIN, NMIN, NMIN, OMAX);
                    end
                end
                4: begin
                    for (int p = 0; p < NUM_PLANES; p++) plane_stage[p] = rand_bits64();
                end
                default: begin
                    stage_frustum(frustum_k);
                end
            endcase
            commit_planes();
            i_cfg_we <= 1'b0;
            repeat (PHASE_ITEMS) begin
                stim_obj = rand_obj(frustum_k);
                send_obj(stim_obj, cull_visible(stim_obj));
            end
            obj_ch.valid <= 1'b0;
            wait_drained();
        end

        repeat (4 * PIPE_DEPTH) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
